FILE: rtl/segsum_pkg.sv
// Package for the segment tree range sum core.
// Holds the tree geometry constants, operation codes and transaction payload types.
// Depends on nothing.
package segsum_pkg;

  localparam int LEAF_BITS   = 10;
  localparam int LEAF_COUNT  = 1 << LEAF_BITS;
  localparam int NODE_BITS   = LEAF_BITS + 1;
  localparam int NODE_COUNT  = 2 * LEAF_COUNT;
  // Walk pointers can reach 2 * LEAF_COUNT, one past the last node.
  localparam int WALK_BITS   = LEAF_BITS + 2;
  localparam int SUM_BITS    = 64;
  localparam int FIELD_BITS  = 10;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [FIELD_BITS-1:0] left_leaf;
    logic [FIELD_BITS-1:0] right_leaf;
    logic [SUM_BITS-1:0]   new_value;
  } in_item_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] range_total;
    logic                bad_range;
    logic                was_update;
  } out_item_t;

endpackage

FILE: rtl/segment_tree_range_sum_core.sv
// Segment tree core with point update and range sum, built around one node memory.
// Depends on segsum_pkg.
//
// The core keeps a sum tree over 1024 leaves in a 2048 x 64 synchronous memory and handles
// one transaction at a time. After reset it runs a clearing pass over all 2048 nodes, one node
// per cycle, with in_ready low. An update reads each node from the leaf to the root and writes
// it back: the leaf with the new value, each ancestor with the difference added. A query reads
// each boundary node that the two climbing paths pick up and adds it to the total. Both go
// through the single memory port with its registered read. An inverted range is answered
// without touching the tree. A finished result sits in an output register, so the next
// transaction is accepted while the previous result still waits.
module segment_tree_range_sum_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  segsum_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output segsum_pkg::out_item_t out_data
);
  import segsum_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_URD  = 3'd2;
  localparam logic [2:0] S_UWR  = 3'd3;
  localparam logic [2:0] S_QLVL = 3'd4;
  localparam logic [2:0] S_QRA  = 3'd5;
  localparam logic [2:0] S_QRB  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [NODE_BITS-1:0] clr_r, clr_nxt;
  logic [NODE_BITS-1:0] node_r, node_nxt;
  logic [SUM_BITS-1:0]  diff_r, diff_nxt;
  logic [SUM_BITS-1:0]  value_r, value_nxt;
  logic                 first_r, first_nxt;
  logic [WALK_BITS-1:0] a_r, a_nxt;
  logic [WALK_BITS-1:0] b_r, b_nxt;
  logic [SUM_BITS-1:0]  total_r, total_nxt;
  logic                 bad_r, bad_nxt;
  logic                 upd_r, upd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [SUM_BITS-1:0]  node_mem [NODE_COUNT];
  logic [SUM_BITS-1:0]  rdata_r;
  logic [NODE_BITS-1:0] mem_raddr;
  logic [NODE_BITS-1:0] mem_waddr;
  logic [SUM_BITS-1:0]  mem_wdata;
  logic                 mem_we;

  logic [LEAF_BITS-1:0] lo_leaf;
  logic [LEAF_BITS-1:0] hi_leaf;
  logic [WALK_BITS-1:0] b_dec;
  logic                 out_load;

  assign lo_leaf  = LEAF_BITS'(in_data.left_leaf);
  assign hi_leaf  = LEAF_BITS'(in_data.right_leaf);
  assign b_dec    = b_r - WALK_BITS'(1);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= node_mem[mem_raddr];
  end

  always_comb begin
    unique case (state_r)
      S_URD:   mem_raddr = node_r;
      S_QLVL:  mem_raddr = a_r[0] ? NODE_BITS'(a_r) : NODE_BITS'(b_dec);
      S_QRA:   mem_raddr = NODE_BITS'(b_dec);
      default: mem_raddr = node_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    node_nxt  = node_r;
    diff_nxt  = diff_r;
    value_nxt = value_r;
    first_nxt = first_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    total_nxt = total_r;
    bad_nxt   = bad_r;
    upd_nxt   = upd_r;
    mem_we    = 1'b0;
    mem_waddr = node_r;
    mem_wdata = rdata_r + diff_r;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + NODE_BITS'(1);
        if (clr_r == {NODE_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          total_nxt = '0;
          bad_nxt   = 1'b0;
          upd_nxt   = 1'b0;
          if (in_data.op == OP_UPDATE) begin
            upd_nxt   = 1'b1;
            node_nxt  = {1'b1, lo_leaf};
            value_nxt = in_data.new_value;
            first_nxt = 1'b1;
            state_nxt = S_URD;
          end else if (hi_leaf < lo_leaf) begin
            bad_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            a_nxt     = {2'b01, lo_leaf};
            b_nxt     = {2'b01, hi_leaf} + WALK_BITS'(1);
            state_nxt = S_QLVL;
          end
        end
      end
      S_URD: begin
        state_nxt = S_UWR;
      end
      S_UWR: begin
        // The leaf takes the new value; its ancestors take the difference to the old one.
        mem_we = 1'b1;
        if (first_r) begin
          mem_wdata = value_r;
          diff_nxt  = value_r - rdata_r;
          first_nxt = 1'b0;
        end
        node_nxt = node_r >> 1;
        if (node_r == NODE_BITS'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_URD;
        end
      end
      S_QLVL: begin
        if (!(a_r < b_r)) begin
          state_nxt = S_DONE;
        end else if (a_r[0]) begin
          a_nxt     = a_r + WALK_BITS'(1);
          state_nxt = S_QRA;
        end else if (b_r[0]) begin
          b_nxt     = b_dec;
          state_nxt = S_QRB;
        end else begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
        end
      end
      S_QRA: begin
        total_nxt = total_r + rdata_r;
        if (b_r[0]) begin
          b_nxt     = b_dec;
          state_nxt = S_QRB;
        end else begin
          a_nxt     = a_r >> 1;
          b_nxt     = b_r >> 1;
          state_nxt = S_QLVL;
        end
      end
      S_QRB: begin
        total_nxt = total_r + rdata_r;
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        state_nxt = S_QLVL;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.range_total = total_r;
      out_data_nxt.bad_range   = bad_r;
      out_data_nxt.was_update  = upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    diff_r     <= diff_nxt;
    value_r    <= value_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    total_r    <= total_nxt;
    bad_r      <= bad_nxt;
    upd_r      <= upd_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted transaction always leaves the idle state on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE && state_r != S_CLR))
    else $error("accepted transaction did not start work");

  // The update climb never writes node zero.
  a_climb_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UWR) |-> (node_r != '0))
    else $error("update climb reached node zero");

  // Stepping the left pointer past a picked-up node never overtakes the right pointer.
  a_walk_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRA) |-> (a_r <= b_r))
    else $error("query walk pointers crossed");

  // A result is never both an update acknowledge and an inverted range.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.bad_range && out_data.was_update))
    else $error("result flags both update and bad range");

endmodule

FILE: tb/segment_tree_range_sum_core_tb.sv
// Self-checking testbench for segment_tree_range_sum_core: leaf updates and range sum queries.
// Depends on segsum_pkg and the core; a small scoreboard keeps its own copy of the leaf values.
`timescale 1ns / 1ps

module segment_tree_range_sum_core_tb;
  import segsum_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // While set, neither side inserts idle cycles.
  bit calm_phase = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;

  segment_tree_range_sum_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  class range_sum_scoreboard;
    logic [SUM_BITS-1:0] leaf_vals [LEAF_COUNT];
    out_item_t           pending_results [$];
    int                  errors = 0;
    int                  updates = 0;
    int                  queries = 0;
    int                  inverted = 0;
    int                  checked = 0;

    function new();
      foreach (leaf_vals[i]) leaf_vals[i] = '0;
    endfunction

    // Predicts the result of one accepted transaction and applies its effect.
    function void note_input(in_item_t item);
      int        lo;
      int        hi;
      out_item_t res;
      lo  = int'(item.left_leaf) & (LEAF_COUNT - 1);
      hi  = int'(item.right_leaf) & (LEAF_COUNT - 1);
      res = '0;
      if (item.op == OP_UPDATE) begin
        leaf_vals[lo]  = item.new_value;
        res.was_update = 1'b1;
        updates++;
      end else if (hi < lo) begin
        res.bad_range = 1'b1;
        inverted++;
      end else begin
        // Every inner node holds its children's sum, so the tree walk equals the leaf sum.
        for (int i = lo; i <= hi; i++) res.range_total += leaf_vals[i];
        queries++;
      end
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [SUM_BITS-1:0] want, logic [SUM_BITS-1:0] seen);
      $display("ERROR at cycle %0d: %s expected 0x%0h, got 0x%0h", cycle_count, what, want, seen);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding, count", SUM_BITS'(0), SUM_BITS'(1));
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.range_total !== want.range_total)
          report_mismatch("range_total", want.range_total, got.range_total);
        if (got.bad_range !== want.bad_range)
          report_mismatch("bad_range", SUM_BITS'(want.bad_range), SUM_BITS'(got.bad_range));
        if (got.was_update !== want.was_update)
          report_mismatch("was_update", SUM_BITS'(want.was_update), SUM_BITS'(got.was_update));
      end
    endtask
  endclass

  range_sum_scoreboard tree_board = new();

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("segment_tree_range_sum_core: mismatch");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SUM_BITS-1:0] rand_sum();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_item(logic op, int lo, int hi, logic [SUM_BITS-1:0] value);
    in_item_t item;
    item.op         = op;
    item.left_leaf  = lo[FIELD_BITS-1:0];
    item.right_leaf = hi[FIELD_BITS-1:0];
    item.new_value  = value;
    return item;
  endfunction

  // Result side: random back-pressure, none while calm_phase is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tree_board.check_result(out_data);
  end

  // Called right after the previous transaction was accepted (or after reset).
  task automatic send_item(in_item_t item);
    int gap;
    gap = calm_phase ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    tree_board.note_input(item);
  endtask

  // Leaves are drawn partly from both ends of the tree so that many get rewritten.
  function automatic int pick_leaf();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(0, 15);
    if (r < 4) return $urandom_range(LEAF_COUNT - 16, LEAF_COUNT - 1);
    return $urandom_range(0, LEAF_COUNT - 1);
  endfunction

  function automatic in_item_t random_item();
    int r;
    int lo;
    int hi;
    int tmp;
    r  = $urandom_range(0, 99);
    lo = pick_leaf();
    hi = pick_leaf();
    if (r < 45) return make_item(OP_UPDATE, lo, $urandom_range(0, LEAF_COUNT - 1), rand_sum());
    if (r < 55) begin
      // Inverted range; equal ends would be a valid query, so force a gap.
      if (lo == hi) hi = (lo + 1) % LEAF_COUNT;
      if (lo < hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      return make_item(OP_QUERY, lo, hi, rand_sum());
    end
    if (r < 75) begin
      hi = lo + $urandom_range(0, 7);
      if (hi >= LEAF_COUNT) hi = LEAF_COUNT - 1;
    end else if (r < 80) begin
      lo = 0;
      hi = LEAF_COUNT - 1;
    end else if (lo > hi) begin
      tmp = lo; lo = hi; hi = tmp;
    end
    return make_item(OP_QUERY, lo, hi, rand_sum());
  endfunction

  initial begin
    logic [SUM_BITS-1:0] all_ones;
    all_ones = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, both operations, inverted ranges, shrinking a leaf.
    send_item(make_item(OP_UPDATE, 0, 0, all_ones));
    send_item(make_item(OP_UPDATE, LEAF_COUNT - 1, LEAF_COUNT - 1, all_ones));
    send_item(make_item(OP_QUERY, 0, LEAF_COUNT - 1, '0));
    send_item(make_item(OP_QUERY, 0, 0, all_ones));
    send_item(make_item(OP_QUERY, LEAF_COUNT - 1, LEAF_COUNT - 1, '0));
    send_item(make_item(OP_QUERY, LEAF_COUNT - 1, 0, '0));
    send_item(make_item(OP_QUERY, 1, 0, all_ones));
    send_item(make_item(OP_UPDATE, 512, 3, 64'h8000_0000_0000_0000));
    send_item(make_item(OP_UPDATE, 511, LEAF_COUNT - 1, 64'h5555_5555_5555_5555));
    send_item(make_item(OP_QUERY, 511, 512, '0));
    send_item(make_item(OP_QUERY, 1, LEAF_COUNT - 2, '0));
    send_item(make_item(OP_UPDATE, 0, 0, '0));
    send_item(make_item(OP_UPDATE, 0, 0, '0));
    send_item(make_item(OP_QUERY, 0, 1, 64'hAAAA_AAAA_AAAA_AAAA));
    send_item(make_item(OP_UPDATE, LEAF_COUNT - 1, 0, 64'd1));
    send_item(make_item(OP_UPDATE, 1, 0, 64'h0123_4567_89AB_CDEF));
    send_item(make_item(OP_QUERY, 0, LEAF_COUNT - 1, '0));
    send_item(make_item(OP_QUERY, 511, 511, '0));
    send_item(make_item(OP_QUERY, 512, LEAF_COUNT - 1, '0));
    send_item(make_item(OP_QUERY, 2, 1, '0));

    // Random part in blocks; every third block runs without idle cycles.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_phase = ((n / 100) % 3) == 2;
      send_item(random_item());
    end
    calm_phase = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (tree_board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tree_board.pending_results.size() != 0)
      tree_board.report_mismatch("outstanding results at end, count", SUM_BITS'(0),
                                 SUM_BITS'(tree_board.pending_results.size()));
    $display("Covered %0d updates, %0d range queries and %0d inverted ranges; %0d results checked.",
             tree_board.updates, tree_board.queries, tree_board.inverted, tree_board.checked);
    $display("Mismatches found: %0d", tree_board.errors);
    if (tree_board.errors == 0) begin
      $display("segment_tree_range_sum_core: match");
    end else begin
      $display("segment_tree_range_sum_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: segment_tree_range_sum_core.f
rtl/segsum_pkg.sv
rtl/segment_tree_range_sum_core.sv
tb/segment_tree_range_sum_core_tb.sv
